FILE: rtl/spit_pkg.sv
package spit_pkg;

   localparam int POS_FRAC_BITS = 16;
   localparam int POS_W         = POS_FRAC_BITS + 1;
   localparam int INC_W         = POS_W + 1;
   localparam int EXT_W         = INC_W + 1;

   localparam int TICK_W    = 32;
   localparam int TIME_FRAC = 8;
   localparam int DT_W      = TICK_W + TIME_FRAC;
   localparam int SPAN_W    = DT_W + 1;

   localparam int TRAVEL_W   = 16;
   localparam int MARGIN_W   = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CMD_W      = 2;
   localparam int DIR_W      = 2;
   localparam int PCT_OUT_W  = 7;

   localparam int DIV_LOW   = TIME_FRAC + 1;
   localparam int DIV_SHIFT = POS_FRAC_BITS - TIME_FRAC;
   localparam int DIV_HI_W  = SPAN_W - DIV_LOW;
   localparam int DIV_CNT_W = $clog2(POS_W + 1);

   localparam int PCT_W = POS_FRAC_BITS + PCT_OUT_W + 1;

   localparam logic [POS_W-1:0]     POS_ONE    = POS_W'(1) << POS_FRAC_BITS;
   localparam logic [INC_W-1:0]     INC_SAT    = INC_W'(1) << POS_W;
   localparam logic [PCT_W-1:0]     PCT_HALF   = PCT_W'(1) << (POS_FRAC_BITS - 1);
   localparam logic [PCT_W-1:0]     PCT_SCALE  = PCT_W'(50);
   localparam logic [PCT_OUT_W-1:0] PCT_MAX    = PCT_OUT_W'(100);

   localparam logic [TRAVEL_W-1:0] UP_TRAVEL_RESET   = TRAVEL_W'(300);
   localparam logic [TRAVEL_W-1:0] DOWN_TRAVEL_RESET = TRAVEL_W'(300);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET      = MARGIN_W'(164);

   localparam logic [CSR_IDX_W-1:0] CSR_UP_TRAVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_TRAVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN      = 2'd2;

   localparam logic [CMD_W-1:0] CMD_EVENT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   localparam logic [DIR_W-1:0] MOTION_STOP = 2'b00;
   localparam logic [DIR_W-1:0] MOTION_UP   = 2'b01;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_START_MIN,
      ST_WAIT_MIN,
      ST_START_MAX,
      ST_WAIT_MAX,
      ST_APPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [SPAN_W-1:0]   dividend;
      logic [TRAVEL_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [INC_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/spit_divider.sv
module spit_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  spit_pkg::div_req_type div_req,
   output spit_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [spit_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [spit_pkg::TRAVEL_W-1:0]      divisor_ff, divisor_in;
   logic [spit_pkg::TRAVEL_W-1:0]      rem_ff, rem_in;
   logic [spit_pkg::POS_W-1:0]         bits_ff, bits_in;
   logic [spit_pkg::INC_W-1:0]         quo_ff, quo_in;

   logic                               sat;
   logic [spit_pkg::TRAVEL_W:0]        trial;
   logic [spit_pkg::TRAVEL_W:0]        diff;
   logic                               fits;

   always_comb begin
      sat   = div_req.dividend[spit_pkg::SPAN_W-1:spit_pkg::DIV_LOW] >=
              spit_pkg::DIV_HI_W'(div_req.divisor);
      trial = {rem_ff, bits_ff[spit_pkg::POS_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      bits_in    = bits_ff;
      quo_in     = quo_ff;
      if (div_req.start) begin
         divisor_in = div_req.divisor;
         rem_in     = div_req.dividend[spit_pkg::DIV_LOW +: spit_pkg::TRAVEL_W];
         bits_in    = spit_pkg::POS_W'(div_req.dividend[spit_pkg::DIV_LOW-1:0])
                      << spit_pkg::DIV_SHIFT;
         if (sat) begin
            quo_in  = spit_pkg::INC_SAT;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            quo_in  = '0;
            cnt_in  = spit_pkg::DIV_CNT_W'(spit_pkg::POS_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[spit_pkg::TRAVEL_W-1:0] : trial[spit_pkg::TRAVEL_W-1:0];
         bits_in = bits_ff << 1;
         quo_in  = {quo_ff[spit_pkg::INC_W-2:0], fits};
         cnt_in  = cnt_ff - spit_pkg::DIV_CNT_W'(1);
         if (cnt_ff == spit_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      bits_ff    <= bits_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> quo_ff <= spit_pkg::INC_SAT)
      else $error("quotient above saturation");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("done while still iterating");

endmodule

FILE: rtl/shutter_position_interval_tracker.sv
// channel | ports                                         | direction
// req     | req_valid, req_stall, command/now_tick/dir    | item in
// rsp     | rsp_valid, rsp_stall, percent/bounds/flags    | item out
// csr     | csr_we, csr_index, csr_wdata                  | register write
//
// Divider use: a move event in motion divides twice (min and max span) on the one shared
// restoring divider, an end check that tests the limit divides once, any other item not at
// all; a saturating quotient needs no iterations. The unused command yields no result.
// Reset: bounds go to [0, 1.0], motion stops, last tick and registers to defaults.
// Stalls: a waiting result is held in the output register while the next item is taken.
module shutter_position_interval_tracker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spit_pkg::CMD_W-1:0]          req_command,
   input  logic [spit_pkg::TICK_W-1:0]         req_now_tick,
   input  logic signed [spit_pkg::DIR_W-1:0]   req_direction,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [spit_pkg::PCT_OUT_W-1:0]      rsp_position_percent,
   output logic [spit_pkg::POS_W-1:0]          rsp_lower_bound,
   output logic [spit_pkg::POS_W-1:0]          rsp_upper_bound,
   output logic                                rsp_notify_clients,
   output logic                                rsp_end_reached,
   input  logic                                csr_we,
   input  logic [spit_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spit_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   spit_pkg::state_type state_ff, state_in;

   logic [spit_pkg::TRAVEL_W-1:0] up_travel_ff, up_travel_in;
   logic [spit_pkg::TRAVEL_W-1:0] down_travel_ff, down_travel_in;
   logic [spit_pkg::MARGIN_W-1:0] margin_ff, margin_in;

   logic [spit_pkg::POS_W-1:0]  pos_low_ff, pos_low_in;
   logic [spit_pkg::POS_W-1:0]  pos_high_ff, pos_high_in;
   logic [spit_pkg::DIR_W-1:0]  motion_ff, motion_in;
   logic [spit_pkg::TICK_W-1:0] last_tick_ff, last_tick_in;

   logic [spit_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [spit_pkg::TICK_W-1:0]   now_ff, now_in;
   logic [spit_pkg::DIR_W-1:0]    dir_ff, dir_in;
   logic [spit_pkg::SPAN_W-1:0]   dmin_ff, dmin_in;
   logic [spit_pkg::SPAN_W-1:0]   dmax_ff, dmax_in;
   logic [spit_pkg::TRAVEL_W-1:0] travel_ff, travel_in;
   logic                          both_ff, both_in;
   logic                          chk_ff, chk_in;
   logic [spit_pkg::INC_W-1:0]    inc_min_ff, inc_min_in;
   logic [spit_pkg::INC_W-1:0]    inc_max_ff, inc_max_in;
   logic                          notify_ff, notify_in;
   logic                          end_ff, end_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [spit_pkg::PCT_OUT_W-1:0]    rsp_pct_ff, rsp_pct_in;
   logic [spit_pkg::POS_W-1:0]        rsp_low_ff, rsp_low_in;
   logic [spit_pkg::POS_W-1:0]        rsp_high_ff, rsp_high_in;
   logic                              rsp_notify_ff, rsp_notify_in;
   logic                              rsp_end_ff, rsp_end_in;

   spit_pkg::div_req_type div_req;
   spit_pkg::div_rsp_type div_rsp;

   logic                          accept;
   logic                          emit;
   logic                          out_free;
   logic                          mv_up;
   logic                          mv_dn;
   logic                          need_both;
   logic                          need_chk;
   logic [spit_pkg::DT_W-1:0]     dt;
   logic [spit_pkg::TRAVEL_W-1:0] travel_sel;
   logic [spit_pkg::EXT_W-1:0]    lo_up;
   logic [spit_pkg::EXT_W-1:0]    hi_up;
   logic [spit_pkg::POS_W-1:0]    lo_up_cap;
   logic [spit_pkg::POS_W-1:0]    hi_up_cap;
   logic [spit_pkg::POS_W-1:0]    lo_dn;
   logic [spit_pkg::POS_W-1:0]    hi_dn;
   logic                          hit;
   logic [spit_pkg::PCT_W-1:0]    pct_full;

   spit_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign mv_up    = motion_ff == spit_pkg::MOTION_UP;
   assign mv_dn    = motion_ff[spit_pkg::DIR_W-1];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spit_pkg::ST_IDLE: begin
            if (req_valid) state_in = spit_pkg::ST_PREP;
         end
         spit_pkg::ST_PREP: begin
            unique case (cmd_ff)
               spit_pkg::CMD_EVENT,
               spit_pkg::CMD_CHECK: begin
                  state_in = (need_both || need_chk) ? spit_pkg::ST_START_MIN
                                                     : spit_pkg::ST_APPLY;
               end
               spit_pkg::CMD_QUERY: state_in = spit_pkg::ST_APPLY;
               default:             state_in = spit_pkg::ST_IDLE;
            endcase
         end
         spit_pkg::ST_START_MIN: state_in = spit_pkg::ST_WAIT_MIN;
         spit_pkg::ST_WAIT_MIN: begin
            if (div_rsp.done) begin
               state_in = both_ff ? spit_pkg::ST_START_MAX : spit_pkg::ST_APPLY;
            end
         end
         spit_pkg::ST_START_MAX: state_in = spit_pkg::ST_WAIT_MAX;
         spit_pkg::ST_WAIT_MAX: begin
            if (div_rsp.done) state_in = spit_pkg::ST_APPLY;
         end
         spit_pkg::ST_APPLY: state_in = spit_pkg::ST_EMIT;
         spit_pkg::ST_EMIT: begin
            if (out_free) state_in = spit_pkg::ST_IDLE;
         end
         default: state_in = spit_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall        = 1'b1;
      emit             = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = dmin_ff;
      div_req.divisor  = travel_ff;
      unique case (state_ff)
         spit_pkg::ST_IDLE:      req_stall = 1'b0;
         spit_pkg::ST_START_MIN: div_req.start = 1'b1;
         spit_pkg::ST_START_MAX: begin
            div_req.start    = 1'b1;
            div_req.dividend = dmax_ff;
         end
         spit_pkg::ST_EMIT:      emit = out_free;
         default: begin
         end
      endcase
   end

   always_comb begin
      dt         = {now_ff - last_tick_ff, {spit_pkg::TIME_FRAC{1'b0}}};
      dmin_in    = dmin_ff;
      dmax_in    = dmax_ff;
      travel_in  = travel_ff;
      both_in    = both_ff;
      chk_in     = chk_ff;
      travel_sel = mv_up ? up_travel_ff : down_travel_ff;
      need_both  = (cmd_ff == spit_pkg::CMD_EVENT) && (mv_up || mv_dn);
      need_chk   = (cmd_ff == spit_pkg::CMD_CHECK) &&
                   ((mv_up && pos_low_ff < spit_pkg::POS_ONE) ||
                    (mv_dn && pos_high_ff != '0));
      if (state_ff == spit_pkg::ST_PREP) begin
         dmin_in   = (dt > spit_pkg::DT_W'(margin_ff))
                     ? spit_pkg::SPAN_W'(dt - spit_pkg::DT_W'(margin_ff)) : '0;
         dmax_in   = spit_pkg::SPAN_W'(dt) + spit_pkg::SPAN_W'(margin_ff);
         travel_in = (travel_sel == '0) ? spit_pkg::TRAVEL_W'(1) : travel_sel;
         both_in   = need_both;
         chk_in    = need_chk;
      end
   end

   always_comb begin
      cmd_in     = accept ? req_command   : cmd_ff;
      now_in     = accept ? req_now_tick  : now_ff;
      dir_in     = accept ? req_direction : dir_ff;
      inc_min_in = (state_ff == spit_pkg::ST_WAIT_MIN && div_rsp.done) ? div_rsp.quotient
                                                                       : inc_min_ff;
      inc_max_in = (state_ff == spit_pkg::ST_WAIT_MAX && div_rsp.done) ? div_rsp.quotient
                                                                       : inc_max_ff;
   end

   always_comb begin
      lo_up     = spit_pkg::EXT_W'(pos_low_ff) + spit_pkg::EXT_W'(inc_min_ff);
      hi_up     = spit_pkg::EXT_W'(pos_high_ff) + spit_pkg::EXT_W'(inc_max_ff);
      lo_up_cap = (lo_up > spit_pkg::EXT_W'(spit_pkg::POS_ONE)) ? spit_pkg::POS_ONE
                                                                : lo_up[spit_pkg::POS_W-1:0];
      hi_up_cap = (hi_up > spit_pkg::EXT_W'(spit_pkg::POS_ONE)) ? spit_pkg::POS_ONE
                                                                : hi_up[spit_pkg::POS_W-1:0];
      lo_dn     = (spit_pkg::INC_W'(pos_low_ff) > inc_max_ff)
                  ? spit_pkg::POS_W'(spit_pkg::INC_W'(pos_low_ff) - inc_max_ff) : '0;
      hi_dn     = (spit_pkg::INC_W'(pos_high_ff) > inc_min_ff)
                  ? spit_pkg::POS_W'(spit_pkg::INC_W'(pos_high_ff) - inc_min_ff) : '0;
      hit       = chk_ff && (mv_up ? (lo_up > spit_pkg::EXT_W'(spit_pkg::POS_ONE))
                                   : (inc_min_ff > spit_pkg::INC_W'(pos_high_ff)));

      pos_low_in   = pos_low_ff;
      pos_high_in  = pos_high_ff;
      motion_in    = motion_ff;
      last_tick_in = last_tick_ff;
      notify_in    = notify_ff;
      end_in       = end_ff;
      if (state_ff == spit_pkg::ST_APPLY) begin
         notify_in = 1'b0;
         end_in    = 1'b0;
         case (cmd_ff)
            spit_pkg::CMD_EVENT: begin
               if (mv_up) begin
                  pos_low_in  = lo_up_cap;
                  pos_high_in = hi_up_cap;
               end else if (mv_dn) begin
                  pos_low_in  = lo_dn;
                  pos_high_in = hi_dn;
               end
               notify_in    = mv_up || mv_dn;
               last_tick_in = now_ff;
               motion_in    = dir_ff;
            end
            spit_pkg::CMD_CHECK: begin
               if (hit) begin
                  pos_low_in  = mv_up ? spit_pkg::POS_ONE : '0;
                  pos_high_in = mv_up ? spit_pkg::POS_ONE : '0;
                  motion_in   = spit_pkg::MOTION_STOP;
               end
               notify_in = hit;
               end_in    = hit;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      up_travel_in   = up_travel_ff;
      down_travel_in = down_travel_ff;
      margin_in      = margin_ff;
      if (csr_we) begin
         unique case (csr_index)
            spit_pkg::CSR_UP_TRAVEL:   up_travel_in   = csr_wdata;
            spit_pkg::CSR_DOWN_TRAVEL: down_travel_in = csr_wdata;
            spit_pkg::CSR_MARGIN:      margin_in      = csr_wdata[spit_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pct_full      = spit_pkg::PCT_W'(spit_pkg::INC_W'(pos_low_ff) +
                                       spit_pkg::INC_W'(pos_high_ff)) * spit_pkg::PCT_SCALE
                      + spit_pkg::PCT_HALF;
      rsp_valid_in  = emit ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_pct_in    = emit ? pct_full[spit_pkg::POS_FRAC_BITS +: spit_pkg::PCT_OUT_W]
                           : rsp_pct_ff;
      rsp_low_in    = emit ? pos_low_ff  : rsp_low_ff;
      rsp_high_in   = emit ? pos_high_ff : rsp_high_ff;
      rsp_notify_in = emit ? notify_ff   : rsp_notify_ff;
      rsp_end_in    = emit ? end_ff      : rsp_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= spit_pkg::ST_IDLE;
         up_travel_ff   <= spit_pkg::UP_TRAVEL_RESET;
         down_travel_ff <= spit_pkg::DOWN_TRAVEL_RESET;
         margin_ff      <= spit_pkg::MARGIN_RESET;
         pos_low_ff     <= '0;
         pos_high_ff    <= spit_pkg::POS_ONE;
         motion_ff      <= spit_pkg::MOTION_STOP;
         last_tick_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         up_travel_ff   <= up_travel_in;
         down_travel_ff <= down_travel_in;
         margin_ff      <= margin_in;
         pos_low_ff     <= pos_low_in;
         pos_high_ff    <= pos_high_in;
         motion_ff      <= motion_in;
         last_tick_ff   <= last_tick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      dir_ff        <= dir_in;
      dmin_ff       <= dmin_in;
      dmax_ff       <= dmax_in;
      travel_ff     <= travel_in;
      both_ff       <= both_in;
      chk_ff        <= chk_in;
      inc_min_ff    <= inc_min_in;
      inc_max_ff    <= inc_max_in;
      notify_ff     <= notify_in;
      end_ff        <= end_in;
      rsp_pct_ff    <= rsp_pct_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_notify_ff <= rsp_notify_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_position_percent = rsp_pct_ff;
   assign rsp_lower_bound      = rsp_low_ff;
   assign rsp_upper_bound      = rsp_high_ff;
   assign rsp_notify_clients   = rsp_notify_ff;
   assign rsp_end_reached      = rsp_end_ff;

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      pos_low_ff <= pos_high_ff && pos_high_ff <= spit_pkg::POS_ONE)
      else $error("position bounds out of order or above full travel");

   a_percent_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_position_percent <= spit_pkg::PCT_MAX)
      else $error("percentage above 100");

   a_end_notifies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_reached |-> rsp_notify_clients)
      else $error("end stop reported without notify");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("second item taken while one is in work");

   a_end_stops_motion: assert property (@(posedge clock) disable iff (reset)
      state_ff == spit_pkg::ST_APPLY && cmd_ff == spit_pkg::CMD_CHECK && hit
      |=> motion_ff == spit_pkg::MOTION_STOP)
      else $error("motion kept after end stop");

endmodule

FILE: verif/tb_shutter_position_interval_tracker.sv
`timescale 1ns / 1ps

module tb_shutter_position_interval_tracker;

   localparam logic [spit_pkg::CMD_W-1:0]     CMD_UNUSED       = 2'd3;
   localparam logic [spit_pkg::CSR_IDX_W-1:0] CSR_UNUSED       = 2'd3;
   localparam logic [spit_pkg::DIR_W-1:0]     MOTION_DOWN      = 2'b11;
   localparam logic [spit_pkg::DIR_W-1:0]     MOTION_DOWN_WIDE = 2'b10;
   localparam int IDLE_LIMIT    = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 250;

   typedef struct packed {
      logic [spit_pkg::PCT_OUT_W-1:0] percent;
      logic [spit_pkg::POS_W-1:0]     lower;
      logic [spit_pkg::POS_W-1:0]     upper;
      logic                           notify;
      logic                           at_stop;
   } shutter_report_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic [spit_pkg::CMD_W-1:0]           req_command = spit_pkg::CMD_QUERY;
   logic [spit_pkg::TICK_W-1:0]          req_now_tick = '0;
   logic signed [spit_pkg::DIR_W-1:0]    req_direction = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic [spit_pkg::PCT_OUT_W-1:0]       rsp_position_percent;
   logic [spit_pkg::POS_W-1:0]           rsp_lower_bound;
   logic [spit_pkg::POS_W-1:0]           rsp_upper_bound;
   logic                                 rsp_notify_clients;
   logic                                 rsp_end_reached;
   logic                                 csr_we = 1'b0;
   logic [spit_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [spit_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   logic [spit_pkg::POS_W-1:0]    model_lower = '0;
   logic [spit_pkg::POS_W-1:0]    model_upper = spit_pkg::POS_ONE;
   logic [spit_pkg::DIR_W-1:0]    model_motion = spit_pkg::MOTION_STOP;
   logic [spit_pkg::TICK_W-1:0]   model_last_tick = '0;
   logic [spit_pkg::TRAVEL_W-1:0] model_up = spit_pkg::UP_TRAVEL_RESET;
   logic [spit_pkg::TRAVEL_W-1:0] model_down = spit_pkg::DOWN_TRAVEL_RESET;
   logic [spit_pkg::MARGIN_W-1:0] model_margin = spit_pkg::MARGIN_RESET;

   shutter_report_type pending_reports[$];
   shutter_report_type want;
   int mismatches = 0;
   int burst_left = 0;
   int quiet_cycles;

   shutter_position_interval_tracker u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_command          (req_command),
      .req_now_tick         (req_now_tick),
      .req_direction        (req_direction),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_position_percent (rsp_position_percent),
      .rsp_lower_bound      (rsp_lower_bound),
      .rsp_upper_bound      (rsp_upper_bound),
      .rsp_notify_clients   (rsp_notify_clients),
      .rsp_end_reached      (rsp_end_reached),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [spit_pkg::INC_W-1:0] travel_fraction(
         input logic [spit_pkg::SPAN_W-1:0] span,
         input logic [spit_pkg::TRAVEL_W-1:0] travel);
      logic [63:0] den;
      logic [63:0] quo;
      den = 64'(travel == '0 ? 16'd1 : travel) << spit_pkg::TIME_FRAC;
      if (64'(span) >= 2 * den) begin
         return spit_pkg::INC_SAT;
      end
      quo = (64'(span) << spit_pkg::POS_FRAC_BITS) / den;
      return quo[spit_pkg::INC_W-1:0];
   endfunction

   task automatic track_position(input logic [spit_pkg::CMD_W-1:0] cmd,
                                 input logic [spit_pkg::TICK_W-1:0] tick,
                                 input logic [spit_pkg::DIR_W-1:0] dir);
      logic [spit_pkg::SPAN_W-1:0] dt;
      logic [spit_pkg::SPAN_W-1:0] dmin;
      logic [spit_pkg::SPAN_W-1:0] dmax;
      logic [spit_pkg::POS_W+1:0]  lo;
      logic [spit_pkg::POS_W+1:0]  hi;
      logic [spit_pkg::INC_W-1:0]  step_lo;
      logic [spit_pkg::INC_W-1:0]  step_hi;
      logic [63:0]                 pct;
      logic                        notify;
      logic                        at_stop;
      int                          heading;
      shutter_report_type          rpt;
      if (cmd == CMD_UNUSED) begin
         return;
      end
      dt = spit_pkg::SPAN_W'({tick - model_last_tick, {spit_pkg::TIME_FRAC{1'b0}}});
      dmin = dt > spit_pkg::SPAN_W'(model_margin) ? dt - spit_pkg::SPAN_W'(model_margin)
                                                  : '0;
      dmax = dt + spit_pkg::SPAN_W'(model_margin);
      heading = model_motion == spit_pkg::MOTION_STOP ? 0 : (model_motion[1] ? -1 : 1);
      lo = (spit_pkg::POS_W+2)'(model_lower);
      hi = (spit_pkg::POS_W+2)'(model_upper);
      notify = 1'b0;
      at_stop = 1'b0;
      if (cmd == spit_pkg::CMD_EVENT) begin
         if (heading > 0) begin
            lo = lo + travel_fraction(dmin, model_up);
            hi = hi + travel_fraction(dmax, model_up);
            if (lo > spit_pkg::POS_ONE) lo = spit_pkg::POS_ONE;
            if (hi > spit_pkg::POS_ONE) hi = spit_pkg::POS_ONE;
         end else if (heading < 0) begin
            step_lo = travel_fraction(dmax, model_down);
            step_hi = travel_fraction(dmin, model_down);
            lo = lo > step_lo ? lo - step_lo : '0;
            hi = hi > step_hi ? hi - step_hi : '0;
         end
         notify = heading != 0;
         model_last_tick = tick;
         model_motion = dir;
      end else if (cmd == spit_pkg::CMD_CHECK) begin
         if (heading > 0 && lo < spit_pkg::POS_ONE) begin
            if (lo + travel_fraction(dmin, model_up) > spit_pkg::POS_ONE) begin
               lo = spit_pkg::POS_ONE;
               hi = spit_pkg::POS_ONE;
               at_stop = 1'b1;
            end
         end else if (heading < 0 && hi != '0) begin
            if (travel_fraction(dmin, model_down) > hi) begin
               lo = '0;
               hi = '0;
               at_stop = 1'b1;
            end
         end
         if (at_stop) model_motion = spit_pkg::MOTION_STOP;
         notify = at_stop;
      end
      model_lower = lo[spit_pkg::POS_W-1:0];
      model_upper = hi[spit_pkg::POS_W-1:0];
      pct = ((64'(lo) + 64'(hi)) * 50 + (64'(1) << (spit_pkg::POS_FRAC_BITS - 1)))
            >> spit_pkg::POS_FRAC_BITS;
      rpt.percent = pct[spit_pkg::PCT_OUT_W-1:0];
      rpt.lower = model_lower;
      rpt.upper = model_upper;
      rpt.notify = notify;
      rpt.at_stop = at_stop;
      pending_reports.push_back(rpt);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic send_item(input logic [spit_pkg::CMD_W-1:0] cmd,
                            input logic [spit_pkg::TICK_W-1:0] tick,
                            input logic [spit_pkg::DIR_W-1:0] dir);
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_now_tick <= tick;
      req_direction <= dir;
      do @(posedge clock); while (req_stall);
      track_position(cmd, tick, dir);
      pace_sender();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [spit_pkg::CSR_DATA_W-1:0] up,
                                  input logic [spit_pkg::CSR_DATA_W-1:0] down,
                                  input logic [spit_pkg::CSR_DATA_W-1:0] margin_word);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= spit_pkg::CSR_UP_TRAVEL;
      csr_wdata <= up;
      @(negedge clock);
      csr_index <= spit_pkg::CSR_DOWN_TRAVEL;
      csr_wdata <= down;
      @(negedge clock);
      csr_index <= spit_pkg::CSR_MARGIN;
      csr_wdata <= margin_word;
      @(negedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= spit_pkg::CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      model_up = up;
      model_down = down;
      model_margin = margin_word[spit_pkg::MARGIN_W-1:0];
   endtask

   task automatic test_reset_state();
      send_item(spit_pkg::CMD_QUERY, 32'd0, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_CHECK, 32'd5, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_EVENT, 32'd10, spit_pkg::MOTION_STOP);
   endtask

   task automatic test_motion_and_end_stops();
      send_item(spit_pkg::CMD_EVENT, 32'd100, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_CHECK, 32'd200, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_QUERY, 32'd200, MOTION_DOWN);
      send_item(spit_pkg::CMD_EVENT, 32'd250, MOTION_DOWN);
      send_item(spit_pkg::CMD_CHECK, 32'd260, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_CHECK, 32'd900, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_EVENT, 32'd1000, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_CHECK, 32'd1400, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_CHECK, 32'd1500, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_EVENT, 32'd1500, MOTION_DOWN_WIDE);
      send_item(spit_pkg::CMD_EVENT, 32'd1650, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_EVENT, 32'hFFFF_FFF0, MOTION_DOWN);
      send_item(spit_pkg::CMD_CHECK, 32'h0000_0100, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_EVENT, 32'hFFFF_FFFF, spit_pkg::MOTION_STOP);
      send_item(CMD_UNUSED, 32'h5A5A_A5A5, MOTION_DOWN_WIDE);
      send_item(spit_pkg::CMD_QUERY, 32'd0, spit_pkg::MOTION_UP);
   endtask

   task automatic test_register_extremes();
      write_registers(16'd1, 16'd1, 16'd0);
      send_item(spit_pkg::CMD_EVENT, 32'd0, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_EVENT, 32'd1, MOTION_DOWN);
      send_item(spit_pkg::CMD_CHECK, 32'd2, spit_pkg::MOTION_STOP);
      send_item(spit_pkg::CMD_CHECK, 32'd3, spit_pkg::MOTION_STOP);
      write_registers(16'hFFFF, 16'hFFFF, 16'd1023);
      send_item(spit_pkg::CMD_EVENT, 32'd10, spit_pkg::MOTION_UP);
      send_item(spit_pkg::CMD_EVENT, 32'd20, spit_pkg::MOTION_STOP);
      write_registers(16'd0, 16'd0, 16'hFFFF);
      send_item(spit_pkg::CMD_EVENT, 32'd25, MOTION_DOWN);
      send_item(spit_pkg::CMD_CHECK, 32'd26, spit_pkg::MOTION_STOP);
   endtask

   task automatic test_random_traffic();
      int phase;
      int sent;
      int pick;
      int unsigned reach;
      logic [spit_pkg::CMD_W-1:0]  cmd;
      logic [spit_pkg::TICK_W-1:0] tick;
      logic [spit_pkg::DIR_W-1:0]  dir;
      tick = $urandom;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               write_registers(spit_pkg::CSR_DATA_W'($urandom_range(1, 600)),
                               spit_pkg::CSR_DATA_W'($urandom_range(1, 600)),
                               spit_pkg::CSR_DATA_W'($urandom_range(0, 1023)));
            end
            1: begin
               write_registers(spit_pkg::CSR_DATA_W'($urandom),
                               spit_pkg::CSR_DATA_W'($urandom),
                               spit_pkg::CSR_DATA_W'($urandom));
            end
            2: begin
               write_registers(16'd1, 16'hFFFF, {6'($urandom), 10'h3FF});
            end
            default: begin
               write_registers(16'hFFFF, 16'd1, 16'd0);
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            cmd = pick < 40 ? spit_pkg::CMD_EVENT : pick < 75 ? spit_pkg::CMD_CHECK :
                  pick < 96 ? spit_pkg::CMD_QUERY : CMD_UNUSED;
            dir = spit_pkg::DIR_W'($urandom_range(0, 3));
            reach = 2 * (model_up > model_down ? model_up : model_down) + 8;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               tick = $urandom;
            end else if (pick > 1) begin
               tick = tick + $urandom_range(0, reach);
            end
            send_item(cmd, tick, dir);
            if (cmd != CMD_UNUSED) sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $error("result item with no expectation waiting");
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_position_percent !== want.percent) begin
               $error("position_percent: expected %0d, actual %0d", want.percent,
                      rsp_position_percent);
               mismatches++;
            end
            if (rsp_lower_bound !== want.lower) begin
               $error("lower_bound: expected %0d, actual %0d", want.lower, rsp_lower_bound);
               mismatches++;
            end
            if (rsp_upper_bound !== want.upper) begin
               $error("upper_bound: expected %0d, actual %0d", want.upper, rsp_upper_bound);
               mismatches++;
            end
            if (rsp_notify_clients !== want.notify) begin
               $error("notify_clients: expected %0d, actual %0d", want.notify,
                      rsp_notify_clients);
               mismatches++;
            end
            if (rsp_end_reached !== want.at_stop) begin
               $error("end_reached: expected %0d, actual %0d", want.at_stop, rsp_end_reached);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 160);
         repeat (span) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_shutter_position_interval_tracker: errors");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_motion_and_end_stops();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      if (mismatches == 0) begin
         $display("tb_shutter_position_interval_tracker: clean");
      end else begin
         $display("tb_shutter_position_interval_tracker: errors");
      end
      $finish;
   end

endmodule

FILE: shutter_position_interval_tracker.f
rtl/spit_pkg.sv
rtl/spit_divider.sv
rtl/shutter_position_interval_tracker.sv
verif/tb_shutter_position_interval_tracker.sv
